>>> hdl/zero_byte_unpacker_unit_assert.svh
// Assertion macros shared by the unpacker RTL.
// Every macro samples on the rising edge of aclk and is off while aresetn is low.
`ifndef ZERO_BYTE_UNPACKER_UNIT_ASSERT_SVH
`define ZERO_BYTE_UNPACKER_UNIT_ASSERT_SVH

// Checks a consequent in the same cycle as its antecedent.
`define ZBU_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define ZBU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/zbu_pkg.sv
`timescale 1ns / 1ps

package zbu_pkg;

    localparam int GROUP_BYTES = 8;
    localparam int GROUP_SHIFT = $clog2(GROUP_BYTES);
    localparam int BIT_IDX_W   = $clog2(GROUP_BYTES);
    localparam int BITPOS_W    = BIT_IDX_W + 1;
    localparam int RAW_W       = 12;
    localparam int COUNT_W     = 16;

    localparam logic [7:0]         RAW_HEADER  = 8'hFF;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_TRUNC = 2'd2,
        KIND_OVER  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_COUNT,
        ST_MASKDATA,
        ST_RAW,
        ST_DISCARD,
        ST_WALK,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic  ld_last;
        logic  ld_mask;
        logic  ld_raw;
        logic  emit_in;
        logic  emit_zero;
        logic  emit_status;
        logic  bitpos_inc;
        logic  raw_dec;
        logic  clear_msg;
        kind_t stat_kind;
    } cmd_t;

    typedef struct packed {
        logic byte_is_raw;
        logic in_last;
        logic raw_last;
        logic ovf_pend;
        logic bit_done;
        logic at_limit;
        logic mask_bit;
        logic last;
        logic out_free;
    } stat_t;

endpackage

>>> hdl/zbu_ctrl.sv
`timescale 1ns / 1ps

module zbu_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  zbu_pkg::stat_t stat,
    output zbu_pkg::cmd_t  cmd
);

    zbu_pkg::state_t state_reg, state_next;
    zbu_pkg::kind_t  kind_reg, kind_next;
    logic            acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= zbu_pkg::ST_HEADER;
            kind_reg  <= zbu_pkg::KIND_DATA;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        unique case (state_reg)
            zbu_pkg::ST_HEADER, zbu_pkg::ST_COUNT,
            zbu_pkg::ST_MASKDATA, zbu_pkg::ST_RAW: s_ready = stat.out_free;
            zbu_pkg::ST_DISCARD:                   s_ready = 1'b1;
            default:                               s_ready = 1'b0;
        endcase
    end

    assign acc = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            zbu_pkg::ST_HEADER: begin
                if (acc) begin
                    if (!stat.byte_is_raw) begin
                        state_next = zbu_pkg::ST_WALK;
                    end else if (stat.in_last) begin
                        kind_next  = zbu_pkg::KIND_TRUNC;
                        state_next = zbu_pkg::ST_STATUS;
                    end else begin
                        state_next = zbu_pkg::ST_COUNT;
                    end
                end
            end
            zbu_pkg::ST_COUNT: begin
                if (acc) begin
                    if (stat.in_last) begin
                        kind_next  = zbu_pkg::KIND_TRUNC;
                        state_next = zbu_pkg::ST_STATUS;
                    end else begin
                        state_next = zbu_pkg::ST_RAW;
                    end
                end
            end
            zbu_pkg::ST_MASKDATA: begin
                if (acc) begin
                    state_next = zbu_pkg::ST_WALK;
                end
            end
            zbu_pkg::ST_RAW: begin
                if (acc) begin
                    // The last run byte settles the run; an earlier end truncates it.
                    if (stat.raw_last) begin
                        if (stat.ovf_pend) begin
                            kind_next  = zbu_pkg::KIND_OVER;
                            state_next = zbu_pkg::ST_STATUS;
                        end else if (stat.in_last) begin
                            kind_next  = zbu_pkg::KIND_DONE;
                            state_next = zbu_pkg::ST_STATUS;
                        end else begin
                            state_next = zbu_pkg::ST_HEADER;
                        end
                    end else if (stat.in_last) begin
                        kind_next  = zbu_pkg::KIND_TRUNC;
                        state_next = zbu_pkg::ST_STATUS;
                    end
                end
            end
            zbu_pkg::ST_DISCARD: begin
                if (acc && stat.in_last) begin
                    state_next = zbu_pkg::ST_HEADER;
                end
            end
            zbu_pkg::ST_WALK: begin
                if (stat.bit_done) begin
                    if (stat.last) begin
                        kind_next  = zbu_pkg::KIND_DONE;
                        state_next = zbu_pkg::ST_STATUS;
                    end else begin
                        state_next = zbu_pkg::ST_HEADER;
                    end
                end else if (stat.at_limit) begin
                    kind_next  = zbu_pkg::KIND_OVER;
                    state_next = zbu_pkg::ST_STATUS;
                end else if (stat.mask_bit) begin
                    if (stat.last) begin
                        kind_next  = zbu_pkg::KIND_TRUNC;
                        state_next = zbu_pkg::ST_STATUS;
                    end else begin
                        state_next = zbu_pkg::ST_MASKDATA;
                    end
                end
            end
            zbu_pkg::ST_STATUS: begin
                if (stat.out_free) begin
                    state_next = stat.last ? zbu_pkg::ST_HEADER : zbu_pkg::ST_DISCARD;
                end
            end
            default: state_next = zbu_pkg::ST_HEADER;
        endcase
    end

    always_comb begin
        cmd           = '0;
        cmd.stat_kind = kind_reg;
        unique case (state_reg)
            zbu_pkg::ST_HEADER: begin
                cmd.ld_last = acc;
                cmd.ld_mask = acc && !stat.byte_is_raw;
            end
            zbu_pkg::ST_COUNT: begin
                cmd.ld_last = acc;
                cmd.ld_raw  = acc;
            end
            zbu_pkg::ST_MASKDATA: begin
                cmd.ld_last    = acc;
                cmd.emit_in    = acc;
                cmd.bitpos_inc = acc;
            end
            zbu_pkg::ST_RAW: begin
                cmd.ld_last = acc;
                cmd.emit_in = acc && !stat.ovf_pend;
                cmd.raw_dec = acc;
            end
            zbu_pkg::ST_DISCARD: begin
                cmd.ld_last   = acc;
                cmd.clear_msg = acc && stat.in_last;
            end
            zbu_pkg::ST_WALK: begin
                // A clear mask bit gives a zero byte once the output register is free.
                if (!stat.bit_done && !stat.at_limit && !stat.mask_bit && stat.out_free) begin
                    cmd.emit_zero  = 1'b1;
                    cmd.bitpos_inc = 1'b1;
                end
            end
            zbu_pkg::ST_STATUS: begin
                cmd.emit_status = stat.out_free;
                cmd.clear_msg   = stat.out_free && stat.last;
            end
            default: cmd.clear_msg = 1'b0;
        endcase
    end

endmodule

>>> hdl/zbu_datapath.sv
`timescale 1ns / 1ps

module zbu_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [7:0]                    s_packed_byte,
    input  logic                          s_message_end,
    input  logic                          cfg_valid,
    input  logic [zbu_pkg::COUNT_W-1:0]   cfg_output_limit,
    input  zbu_pkg::cmd_t                 cmd,
    output zbu_pkg::stat_t                stat,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [1:0]                    m_kind,
    output logic [7:0]                    m_plain_byte,
    output logic [zbu_pkg::COUNT_W-1:0]   m_total_length,
    output logic                          m_final_item
);

    logic [7:0]                   mask_reg, mask_next;
    logic [zbu_pkg::BITPOS_W-1:0] bitpos_reg, bitpos_next;
    logic [zbu_pkg::RAW_W-1:0]    raw_reg, raw_next;
    logic [zbu_pkg::COUNT_W-1:0]  written_reg, written_next;
    logic                         ovf_reg, ovf_next;
    logic                         last_reg, last_next;
    logic [zbu_pkg::COUNT_W-1:0]  limit_reg, limit_next;

    logic                         m_valid_reg, m_valid_next;
    zbu_pkg::kind_t               m_kind_reg, m_kind_next;
    logic [7:0]                   m_byte_reg, m_byte_next;
    logic [zbu_pkg::COUNT_W-1:0]  m_total_reg, m_total_next;
    logic                         m_final_reg, m_final_next;

    logic [zbu_pkg::COUNT_W-1:0]  written_plus1;
    logic [zbu_pkg::RAW_W-1:0]    raw_load;
    logic [zbu_pkg::COUNT_W:0]    raw_end;
    logic                         emit_any;

    assign written_plus1 = written_reg + zbu_pkg::COUNT_W'(1);
    assign raw_load = (zbu_pkg::RAW_W'(s_packed_byte) + zbu_pkg::RAW_W'(1))
                      << zbu_pkg::GROUP_SHIFT;
    assign raw_end  = {1'b0, written_reg} + (zbu_pkg::COUNT_W + 1)'(raw_load);
    assign emit_any = cmd.emit_in || cmd.emit_zero || cmd.emit_status;

    always_comb begin
        mask_next    = mask_reg;
        bitpos_next  = bitpos_reg;
        raw_next     = raw_reg;
        written_next = written_reg;
        ovf_next     = ovf_reg;
        last_next    = last_reg;
        limit_next   = cfg_valid ? cfg_output_limit : limit_reg;

        if (cmd.ld_last) begin
            last_next = s_message_end;
        end
        if (cmd.ld_mask) begin
            mask_next   = s_packed_byte;
            bitpos_next = '0;
        end
        if (cmd.bitpos_inc) begin
            bitpos_next = bitpos_reg + zbu_pkg::BITPOS_W'(1);
        end
        if (cmd.ld_raw) begin
            raw_next = raw_load;
            ovf_next = raw_end > {1'b0, limit_reg};
        end
        if (cmd.raw_dec) begin
            raw_next = raw_reg - zbu_pkg::RAW_W'(1);
        end
        if (cmd.emit_in || cmd.emit_zero) begin
            written_next = written_plus1;
        end
        if (cmd.clear_msg) begin
            mask_next    = '0;
            bitpos_next  = '0;
            raw_next     = '0;
            written_next = '0;
            ovf_next     = 1'b0;
        end
    end

    always_comb begin
        m_kind_next  = m_kind_reg;
        m_byte_next  = m_byte_reg;
        m_total_next = m_total_reg;
        m_final_next = m_final_reg;
        if (cmd.emit_in || cmd.emit_zero) begin
            m_kind_next  = zbu_pkg::KIND_DATA;
            m_byte_next  = cmd.emit_in ? s_packed_byte : 8'd0;
            m_total_next = written_plus1;
            m_final_next = 1'b0;
        end else if (cmd.emit_status) begin
            m_kind_next  = cmd.stat_kind;
            m_byte_next  = 8'd0;
            m_total_next = written_reg;
            m_final_next = 1'b1;
        end
        if (emit_any) begin
            m_valid_next = 1'b1;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            bitpos_reg  <= '0;
            raw_reg     <= '0;
            written_reg <= '0;
            ovf_reg     <= 1'b0;
            last_reg    <= 1'b0;
            limit_reg   <= zbu_pkg::LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            mask_reg    <= mask_next;
            bitpos_reg  <= bitpos_next;
            raw_reg     <= raw_next;
            written_reg <= written_next;
            ovf_reg     <= ovf_next;
            last_reg    <= last_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg  <= m_kind_next;
        m_byte_reg  <= m_byte_next;
        m_total_reg <= m_total_next;
        m_final_reg <= m_final_next;
    end

    always_comb begin
        stat.byte_is_raw = s_packed_byte == zbu_pkg::RAW_HEADER;
        stat.in_last     = s_message_end;
        stat.raw_last    = raw_reg == zbu_pkg::RAW_W'(1);
        stat.ovf_pend    = ovf_reg;
        stat.bit_done    = bitpos_reg == zbu_pkg::BITPOS_W'(zbu_pkg::GROUP_BYTES);
        stat.at_limit    = written_reg >= limit_reg;
        stat.mask_bit    = mask_reg[bitpos_reg[zbu_pkg::BIT_IDX_W-1:0]];
        stat.last        = last_reg;
        stat.out_free    = !m_valid_reg || m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_plain_byte   = m_byte_reg;
    assign m_total_length = m_total_reg;
    assign m_final_item   = m_final_reg;

endmodule

>>> hdl/zero_byte_unpacker_unit.sv
// A result reaches the m_ side in the cycle after the byte or walk step that makes it.
// Throughput: one input byte per cycle while the output register is free; a mask header then
// walks its eight bits one step per bit, one result per cycle out of the single output
// register while it is free, plus a step at the group end and a step for each status item.
// Reset (aresetn low, synchronous): header phase, counters cleared, output_limit = 65535.
`timescale 1ns / 1ps

`include "zero_byte_unpacker_unit_assert.svh"

module zero_byte_unpacker_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_packed_byte,
    input  logic                        s_message_end,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [zbu_pkg::COUNT_W-1:0] cfg_output_limit,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_kind,
    output logic [7:0]                  m_plain_byte,
    output logic [zbu_pkg::COUNT_W-1:0] m_total_length,
    output logic                        m_final_item
);

    zbu_pkg::cmd_t  cmd;
    zbu_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    zbu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    zbu_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_packed_byte    (s_packed_byte),
        .s_message_end    (s_message_end),
        .cfg_valid        (cfg_valid),
        .cfg_output_limit (cfg_output_limit),
        .cmd              (cmd),
        .stat             (stat),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_kind           (m_kind),
        .m_plain_byte     (m_plain_byte),
        .m_total_length   (m_total_length),
        .m_final_item     (m_final_item)
    );

    // While a data result is stalled, no input transaction may be taken. Discarded bytes
    // after an error may still pass a waiting status item, since they produce nothing.
    `ZBU_ASSERT_SAME(a_no_accept_on_stall, s_ready && m_valid && !m_final_item, m_ready, "input taken while output stalled")
    // A status item carries a status kind and a zero byte.
    `ZBU_ASSERT_SAME(a_status_shape, m_valid && m_final_item, (m_kind != zbu_pkg::KIND_DATA) && (m_plain_byte == 8'd0), "malformed status item")
    // Nothing follows a status item in the very next cycle.
    `ZBU_ASSERT_NEXT(a_gap_after_status, m_valid && m_ready && m_final_item, !m_valid, "result right after status item")

endmodule
